/* hw/rtl/sac_pkg.sv */
// ----------------------------------------------------------------------------
// sac_pkg
// shared constants and types of the set-associative cache tag model
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int ADDR_BITS = 48;
    localparam int TAG_W     = 48;
    localparam int CNT_W     = 32;
    localparam int MAX_SETS  = 256;
    localparam int SET_W     = $clog2(MAX_SETS);
    localparam int MAX_WAYS  = 8;
    localparam int WAY_W     = $clog2(MAX_WAYS);
    localparam int LFSR_W    = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LRU_MODE  = 2'd3;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    // one way of a set: valid flag and tag
    typedef struct packed {
        logic             v;
        logic [TAG_W-1:0] tag;
    } t_way;

    typedef t_way [MAX_WAYS-1:0] t_row;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // capture address, start the set read
        logic commit;   // write the set back, step counters, load result
    } t_cmd;

endpackage

/* hw/rtl/sac_ctrl.sv */
// ----------------------------------------------------------------------------
// sac_ctrl
// sequencer for lookup and update, plus the result valid flag
// ----------------------------------------------------------------------------
module sac_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sac_pkg::t_cmd o_cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_UPDATE = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic accept;
    logic commit;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    // result register is free, or is being emptied this cycle
    assign commit     = (r_state == S_UPDATE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cmd.accept = accept;
    assign o_cmd.commit = commit;

endmodule

/* hw/rtl/sac_dp.sv */
// ----------------------------------------------------------------------------
// sac_dp
// address split, tag memory, way compare, replacement and counters
// ----------------------------------------------------------------------------
module sac_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sac_pkg::t_cmd                    i_cmd,
    input  logic                             i_cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [sac_pkg::ADDR_BITS-1:0]    i_address,
    output logic                             o_hit,
    output logic [sac_pkg::SET_W-1:0]        o_set_index,
    output logic [sac_pkg::TAG_W-1:0]        o_tag_value,
    output logic [sac_pkg::CNT_W-1:0]        o_access_total,
    output logic [sac_pkg::CNT_W-1:0]        o_miss_total
);

    // remainder of a pseudo-random value by the way count (1..8)
    function automatic logic [sac_pkg::WAY_W-1:0] f_mod_ways(
        input logic [sac_pkg::LFSR_W-1:0] x,
        input logic [sac_pkg::WAY_W:0]    w
    );
        logic [5:0] s7;
        logic [3:0] t7;
        logic [4:0] s3;
        logic [2:0] t3;
        logic [5:0] s5;
        logic [4:0] t5;
        logic [2:0] m3;
        logic [2:0] m5;
        logic [2:0] m6;
        logic [2:0] m7;
        logic [2:0] res;
        // 8 = 1 mod 7: fold 3-bit digits
        s7 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12])
           + 6'(x[15]);
        t7 = 4'(s7[2:0]) + 4'(s7[5:3]);
        m7 = (t7 >= 4'd7) ? 3'(t7 - 4'd7) : t7[2:0];
        // 4 = 1 mod 3: fold 2-bit digits
        s3 = 5'(x[1:0]) + 5'(x[3:2]) + 5'(x[5:4]) + 5'(x[7:6]) + 5'(x[9:8])
           + 5'(x[11:10]) + 5'(x[13:12]) + 5'(x[15:14]);
        t3 = 3'(s3[1:0]) + 3'(s3[3:2]) + 3'(s3[4]);
        if (t3 >= 3'd6) begin
            m3 = t3 - 3'd6;
        end else if (t3 >= 3'd3) begin
            m3 = t3 - 3'd3;
        end else begin
            m3 = t3;
        end
        // 16 = 1 mod 5: fold nibbles
        s5 = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]) + 6'(x[15:12]);
        t5 = 5'(s5[3:0]) + 5'(s5[5:4]);
        if (t5 >= 5'd15) begin
            m5 = 3'(t5 - 5'd15);
        end else if (t5 >= 5'd10) begin
            m5 = 3'(t5 - 5'd10);
        end else if (t5 >= 5'd5) begin
            m5 = 3'(t5 - 5'd5);
        end else begin
            m5 = t5[2:0];
        end
        // mod 6 from mod 3 and parity
        m6 = m3 + (((m3[0] ^ x[0]) != 1'b0) ? 3'd3 : 3'd0);
        case (w)
            4'd2:    res = {2'b00, x[0]};
            4'd3:    res = m3;
            4'd4:    res = {1'b0, x[1:0]};
            4'd5:    res = m5;
            4'd6:    res = m6;
            4'd7:    res = m7;
            4'd8:    res = x[2:0];
            default: res = 3'd0;
        endcase
        return res;
    endfunction

    // configuration
    logic [4:0] r_line_bits;
    logic [3:0] r_set_bits;
    logic [3:0] r_ways_used;
    logic       r_lru_mode;

    logic [4:0]                  lb;
    logic [3:0]                  sb;
    logic [sac_pkg::WAY_W:0]     w;
    logic [sac_pkg::WAY_W-1:0]   w_last;

    // address split
    logic [sac_pkg::ADDR_BITS-1:0] addr_sh;
    logic [sac_pkg::SET_W-1:0]     set_mask;
    logic [sac_pkg::SET_W-1:0]     n_set;
    logic [sac_pkg::TAG_W-1:0]     n_tag;
    logic [sac_pkg::SET_W-1:0]     r_set;
    logic [sac_pkg::TAG_W-1:0]     r_tag;

    // storage
    sac_pkg::t_row               r_mem [sac_pkg::MAX_SETS];
    logic [sac_pkg::MAX_SETS-1:0] r_row_ok;
    sac_pkg::t_row               r_rd_row;
    logic                        r_rd_ok;

    // compare and replace
    sac_pkg::t_row                   eff_row;
    sac_pkg::t_row                   n_row;
    logic [sac_pkg::MAX_WAYS-1:0]    match;
    logic                            hit;
    logic [sac_pkg::WAY_W-1:0]       hit_way;
    logic [sac_pkg::WAY_W-1:0]       limit;
    logic [sac_pkg::WAY_W-1:0]       pos;
    sac_pkg::t_way                   new_way;

    // counters and lfsr
    logic [sac_pkg::CNT_W-1:0]  r_acc;
    logic [sac_pkg::CNT_W-1:0]  n_acc;
    logic [sac_pkg::CNT_W-1:0]  r_miss;
    logic [sac_pkg::CNT_W-1:0]  n_miss;
    logic [sac_pkg::LFSR_W-1:0] r_lfsr;
    logic [sac_pkg::LFSR_W-1:0] n_lfsr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bits <= 5'd5;
            r_set_bits  <= 4'd4;
            r_ways_used <= 4'd1;
            r_lru_mode  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sac_pkg::CFG_LINE_BITS: r_line_bits <= i_cfg_data;
                sac_pkg::CFG_SET_BITS:  r_set_bits  <= i_cfg_data[3:0];
                sac_pkg::CFG_WAYS_USED: r_ways_used <= i_cfg_data[3:0];
                sac_pkg::CFG_LRU_MODE:  r_lru_mode  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // clamp out-of-range settings
    assign lb = (r_line_bits > 5'd16) ? 5'd16 : r_line_bits;
    assign sb = (r_set_bits > 4'd8) ? 4'd8 : r_set_bits;
    always_comb begin
        if (r_ways_used == 4'd0) begin
            w = 4'd1;
        end else if (r_ways_used > 4'(sac_pkg::MAX_WAYS)) begin
            w = 4'(sac_pkg::MAX_WAYS);
        end else begin
            w = r_ways_used;
        end
    end
    assign w_last = 3'(w - 4'd1);

    assign addr_sh  = i_address >> lb;
    assign set_mask = ~(8'hFF << sb);
    assign n_set    = addr_sh[sac_pkg::SET_W-1:0] & set_mask;
    assign n_tag    = i_address >> (lb + 5'(sb));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_set <= n_set;
            r_tag <= n_tag;
        end
    end

    // tag memory, one row per set, read on accept and written on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd_row <= r_mem[n_set];
        end
        if (i_cmd.commit) begin
            r_mem[r_set] <= n_row;
        end
    end

    // row-written flags stand in for clearing the whole memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_rd_ok <= r_row_ok[n_set];
            end
            if (i_cmd.commit) begin
                r_row_ok[r_set] <= 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < sac_pkg::MAX_WAYS; i++) begin
            eff_row[i].tag = r_rd_row[i].tag;
            eff_row[i].v   = r_rd_row[i].v && r_rd_ok;
            match[i]       = eff_row[i].v && (eff_row[i].tag == r_tag)
                             && (4'(i) < w);
        end
    end

    assign hit = |match;

    // lowest matching way
    always_comb begin
        hit_way = '0;
        for (int i = sac_pkg::MAX_WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_way = 3'(i);
            end
        end
    end

    assign n_lfsr = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5],
                     r_lfsr[sac_pkg::LFSR_W-1:1]};
    assign pos     = f_mod_ways(n_lfsr, w);
    assign limit   = hit ? hit_way : w_last;
    assign new_way = '{v: 1'b1, tag: r_tag};

    always_comb begin
        n_row = eff_row;
        if (r_lru_mode) begin
            // move to front, shifting ways down to the hit way or the last way
            n_row[0] = new_way;
            for (int i = 1; i < sac_pkg::MAX_WAYS; i++) begin
                if (3'(i) <= limit) begin
                    n_row[i] = eff_row[i-1];
                end
            end
        end else if (!hit) begin
            n_row[pos] = new_way;
        end
    end

    assign n_acc  = (r_acc == '1) ? r_acc : r_acc + 32'd1;
    assign n_miss = (hit || (r_miss == '1)) ? r_miss : r_miss + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_miss <= '0;
            r_lfsr <= sac_pkg::LFSR_SEED;
        end else if (i_cmd.commit) begin
            r_acc  <= n_acc;
            r_miss <= n_miss;
            if (!r_lru_mode && !hit) begin
                r_lfsr <= n_lfsr;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_hit          <= hit;
            o_set_index    <= r_set;
            o_tag_value    <= r_tag;
            o_access_total <= n_acc;
            o_miss_total   <= n_miss;
        end
    end

endmodule

/* hw/rtl/set_assoc_cache_tag_sim.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_sim
// set-associative cache tag lookup with lru or random replacement
// ----------------------------------------------------------------------------
// result valid is registered on commit in the update state, which follows the
//   accept; a new address is taken only after the previous one is written back,
//   as the tag memory row is read in idle and the reordered row written in update
// a stalled result holds the update state until the result register frees
// reset (synchronous): counters zero, lfsr 0xace1, config to defaults, all
//   rows flagged unwritten; tag memory contents are not cleared, no sweep
module set_assoc_cache_tag_sim (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // address transactions
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sac_pkg::ADDR_BITS-1:0]   i_address,
    // result transactions
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_hit,
    output logic [sac_pkg::SET_W-1:0]       o_set_index,
    output logic [sac_pkg::TAG_W-1:0]       o_tag_value,
    output logic [sac_pkg::CNT_W-1:0]       o_access_total,
    output logic [sac_pkg::CNT_W-1:0]       o_miss_total,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [sac_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // accept / commit strobes
    sac_pkg::t_cmd cmd;

    // sequencer: idle takes an address and starts the set read,
    // update compares the ways and writes the set back
    sac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // address split, tag memory, replacement, counters, result register
    sac_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_address      (i_address),
        .o_hit          (o_hit),
        .o_set_index    (o_set_index),
        .o_tag_value    (o_tag_value),
        .o_access_total (o_access_total),
        .o_miss_total   (o_miss_total)
    );

endmodule
